// ===== design/tfr_pkg.sv =====
// ----------------------------------------------------------------------------
// tfr_pkg: shared types and constants for the thrust-to-RPM converter
// Field widths, internal datapath widths, register indexes and the records
// that travel with an item through the square-root and divider cell rows.
// ----------------------------------------------------------------------------
package tfr_pkg;

   // Default curve mode: nonzero selects coefficient mode, zero physical mode.
   localparam int CURVE_MODE_DEF = 1;

   localparam int COEF_W  = 32;
   localparam int CLAMP_W = 16;
   localparam int FORCE_W = 24;
   localparam int SURGE_W = 16;
   localparam int RPM_W   = 16;
   localparam int IDX_W   = 3;

   // Datapath widths; the terms and the root are at 2^-32, the discriminant at 2^-64.
   localparam int B_W     = 48;            // signed linear term
   localparam int C_W     = 49;            // signed constant term
   localparam int RAD_W   = 94;            // discriminant
   localparam int ROOT_W  = RAD_W / 2;     // square root, one bit per cell
   localparam int SQ_REM_W = ROOT_W + 3;   // partial remainder of the root
   localparam int NUM_W   = 54;            // magnitude of the numerator
   localparam int DEN_W   = 41;            // magnitude of 2a

   typedef enum logic [IDX_W-1:0] {
      REG_FWD_QUAD  = 3'd0,
      REG_FWD_LIN   = 3'd1,
      REG_FWD_CONST = 3'd2,
      REG_BWD_QUAD  = 3'd3,
      REG_BWD_LIN   = 3'd4,
      REG_BWD_CONST = 3'd5,
      REG_RPM_CEIL  = 3'd6,
      REG_RPM_FLOOR = 3'd7
   } csr_idx_type;

   localparam logic signed [CLAMP_W-1:0] CEIL_RST  = 16'sh7FFF;
   localparam logic signed [CLAMP_W-1:0] FLOOR_RST = 16'sh8000;

   // Item record carried through the square-root row.
   typedef struct packed {
      logic                  neg;
      logic                  err;
      logic                  zero;
      logic                  last;
      logic signed [B_W-1:0] b;
   } sq_tag_type;

   // Item record carried through the divider row.
   typedef struct packed {
      logic neg;
      logic err;
      logic zero;
      logic last;
      logic qneg;
   } dv_tag_type;

endpackage

// ===== design/thrust_force_to_rpm.sv =====
// ----------------------------------------------------------------------------
// thrust_force_to_rpm: thruster force to RPM command by curve inversion
// Solves the quadratic thrust curve for RPM with a row of square-root cells
// and a row of divider cells, one item per clock while the row is not stalled.
// ----------------------------------------------------------------------------
// The block takes one force transfer per clock while req_ready is high and
// returns one RPM transfer for each, in order. An accepted force passes
// five front stages (operand setup, partial products, discriminant),
// 47 square-root cells that settle one root bit each, one numerator stage,
// 54 divider cells that settle one quotient bit each and the output register.
// The row takes one item per clock while not stalled, as every cell hands its
// work to its neighbor on each advance. A result that is not taken stalls the
// whole row only once a second result is waiting in the skid register behind it.
// Coefficient registers must be written while no item is in flight.
// ----------------------------------------------------------------------------
module thrust_force_to_rpm #(
   parameter int CURVE_MODE = tfr_pkg::CURVE_MODE_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [tfr_pkg::FORCE_W-1:0]  req_thrust_force,
   input  logic signed [tfr_pkg::SURGE_W-1:0]  req_surge_speed,
   input  logic                                req_last_thruster,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [tfr_pkg::RPM_W-1:0]    rsp_rpm_command,
   output logic                                rsp_math_error,
   output logic                                rsp_last_rpm,
   input  logic                                csr_we,
   input  logic [tfr_pkg::IDX_W-1:0]           csr_index,
   input  logic [tfr_pkg::COEF_W-1:0]          csr_wdata
);

   localparam bit PHYS = (CURVE_MODE == 0);
   localparam int ROOT_W = tfr_pkg::ROOT_W;
   localparam int NUM_W  = tfr_pkg::NUM_W;
   localparam logic signed [55:0] RPM_MAX = 56'sd32767;
   localparam logic signed [55:0] RPM_MIN = -56'sd32768;

   // ---------------------------------------------------------------------
   // Configuration registers.
   // ---------------------------------------------------------------------
   logic signed [tfr_pkg::COEF_W-1:0]  fwd_quad_ff, fwd_lin_ff, fwd_const_ff;
   logic signed [tfr_pkg::COEF_W-1:0]  bwd_quad_ff, bwd_lin_ff, bwd_const_ff;
   logic signed [tfr_pkg::CLAMP_W-1:0] rpm_ceil_ff, rpm_floor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_quad_ff  <= '0;
         fwd_lin_ff   <= '0;
         fwd_const_ff <= '0;
         bwd_quad_ff  <= '0;
         bwd_lin_ff   <= '0;
         bwd_const_ff <= '0;
         rpm_ceil_ff  <= tfr_pkg::CEIL_RST;
         rpm_floor_ff <= tfr_pkg::FLOOR_RST;
      end else if (csr_we) begin
         case (tfr_pkg::csr_idx_type'(csr_index))
            tfr_pkg::REG_FWD_QUAD:  fwd_quad_ff  <= csr_wdata;
            tfr_pkg::REG_FWD_LIN:   fwd_lin_ff   <= csr_wdata;
            tfr_pkg::REG_FWD_CONST: fwd_const_ff <= csr_wdata;
            tfr_pkg::REG_BWD_QUAD:  bwd_quad_ff  <= csr_wdata;
            tfr_pkg::REG_BWD_LIN:   bwd_lin_ff   <= csr_wdata;
            tfr_pkg::REG_BWD_CONST: bwd_const_ff <= csr_wdata;
            tfr_pkg::REG_RPM_CEIL:  rpm_ceil_ff  <= csr_wdata[tfr_pkg::CLAMP_W-1:0];
            tfr_pkg::REG_RPM_FLOOR: rpm_floor_ff <= csr_wdata[tfr_pkg::CLAMP_W-1:0];
            default: ;
         endcase
      end
   end

   // The whole row advances together; it holds only when the skid register
   // is occupied.
   logic adv;
   logic skid_valid_ff;
   assign adv       = !skid_valid_ff;
   assign req_ready = adv;

   // ---------------------------------------------------------------------
   // Stage 1: input register.
   // ---------------------------------------------------------------------
   logic                               p1_valid_ff, p1_last_ff;
   logic signed [tfr_pkg::FORCE_W-1:0] p1_force_ff;
   logic signed [tfr_pkg::SURGE_W-1:0] p1_surge_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (adv) begin
         p1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_force_ff <= req_thrust_force;
         p1_surge_ff <= req_surge_speed;
         p1_last_ff  <= req_last_thruster;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: select the coefficient set and build a, b and c at 2^-32.
   // The forward set serves positive force, the backward set negative force;
   // the physical mode always uses the forward registers.
   // ---------------------------------------------------------------------
   logic                               p2_neg_in, p2_zero_in;
   logic signed [tfr_pkg::COEF_W-1:0]  sel_b, sel_c;
   logic [tfr_pkg::FORCE_W-1:0]        force_mag;
   logic signed [tfr_pkg::B_W-1:0]     k_surge;
   logic signed [tfr_pkg::COEF_W-1:0]  p2_a_in, p2_a_ff;
   logic signed [tfr_pkg::B_W-1:0]     p2_b_in, p2_b_ff;
   logic signed [tfr_pkg::C_W-1:0]     p2_c_in, p2_c_ff;
   logic                               p2_valid_ff, p2_neg_ff, p2_zero_ff, p2_last_ff;

   always_comb begin
      p2_neg_in  = p1_force_ff[tfr_pkg::FORCE_W-1];
      p2_zero_in = (p1_force_ff == '0);
      p2_a_in    = (!PHYS && p2_neg_in) ? bwd_quad_ff  : fwd_quad_ff;
      sel_b      = (!PHYS && p2_neg_in) ? bwd_lin_ff   : fwd_lin_ff;
      sel_c      = (!PHYS && p2_neg_in) ? bwd_const_ff : fwd_const_ff;
      force_mag  = p2_neg_in ? tfr_pkg::FORCE_W'(-p1_force_ff)
                             : tfr_pkg::FORCE_W'(p1_force_ff);
      k_surge    = fwd_lin_ff * p1_surge_ff;
      if (PHYS) begin
         p2_b_in = -k_surge;
         p2_c_in = -$signed({1'b0, force_mag, 24'b0});
      end else begin
         p2_b_in = {{8{sel_b[tfr_pkg::COEF_W-1]}}, sel_b, 8'b0};
         p2_c_in = $signed({{9{sel_c[tfr_pkg::COEF_W-1]}}, sel_c, 8'b0})
                 - $signed({p1_force_ff[tfr_pkg::FORCE_W-1], p1_force_ff, 24'b0});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else if (adv) begin
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p2_a_ff    <= p2_a_in;
         p2_b_ff    <= p2_b_in;
         p2_c_ff    <= p2_c_in;
         p2_neg_ff  <= p2_neg_in;
         p2_zero_ff <= p2_zero_in;
         p2_last_ff <= p1_last_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: partial products of b^2 and 4|a||c|, split at 24 bits.
   // a carries a factor of 2^8 and the 4 another 2^2, applied as a shift.
   // ---------------------------------------------------------------------
   logic [31:0] a_mag;
   logic [46:0] b_mag;
   logic [47:0] c_mag;
   logic [45:0] p3_bhh_in, p3_bhh_ff;
   logic [46:0] p3_bhl_in, p3_bhl_ff;
   logic [47:0] p3_bll_in, p3_bll_ff;
   logic [55:0] p3_thi_in, p3_thi_ff, p3_tlo_in, p3_tlo_ff;
   logic        p3_add_in, p3_add_ff, p3_azero_in, p3_azero_ff;
   logic        p3_valid_ff, p3_neg_ff, p3_zero_ff, p3_last_ff;
   logic signed [tfr_pkg::B_W-1:0] p3_b_ff;

   always_comb begin
      a_mag = p2_a_ff[tfr_pkg::COEF_W-1] ? 32'(-p2_a_ff) : 32'(p2_a_ff);
      b_mag = p2_b_ff[tfr_pkg::B_W-1] ? 47'(-p2_b_ff) : 47'(p2_b_ff);
      c_mag = p2_c_ff[tfr_pkg::C_W-1] ? 48'(-p2_c_ff) : 48'(p2_c_ff);
      p3_bhh_in   = b_mag[46:24] * b_mag[46:24];
      p3_bhl_in   = b_mag[46:24] * b_mag[23:0];
      p3_bll_in   = b_mag[23:0] * b_mag[23:0];
      p3_thi_in   = a_mag * c_mag[47:24];
      p3_tlo_in   = a_mag * c_mag[23:0];
      // With opposite signs of a and c the discriminant is a plain sum.
      p3_add_in   = (p2_a_ff[tfr_pkg::COEF_W-1] != p2_c_ff[tfr_pkg::C_W-1]);
      p3_azero_in = (p2_a_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_valid_ff <= 1'b0;
      end else if (adv) begin
         p3_valid_ff <= p2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p3_bhh_ff   <= p3_bhh_in;
         p3_bhl_ff   <= p3_bhl_in;
         p3_bll_ff   <= p3_bll_in;
         p3_thi_ff   <= p3_thi_in;
         p3_tlo_ff   <= p3_tlo_in;
         p3_add_ff   <= p3_add_in;
         p3_azero_ff <= p3_azero_in;
         p3_b_ff     <= p2_b_ff;
         p3_neg_ff   <= p2_neg_ff;
         p3_zero_ff  <= p2_zero_ff;
         p3_last_ff  <= p2_last_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 4: sum the partial products.
   // ---------------------------------------------------------------------
   logic [tfr_pkg::RAD_W-1:0] p4_bsq_in, p4_bsq_ff, p4_t_in, p4_t_ff;
   logic p4_valid_ff, p4_add_ff, p4_azero_ff, p4_neg_ff, p4_zero_ff, p4_last_ff;
   logic signed [tfr_pkg::B_W-1:0] p4_b_ff;

   always_comb begin
      p4_bsq_in = {p3_bhh_ff, 48'b0} + tfr_pkg::RAD_W'({p3_bhl_ff, 25'b0})
                + tfr_pkg::RAD_W'(p3_bll_ff);
      p4_t_in   = tfr_pkg::RAD_W'({p3_thi_ff, 34'b0})
                + tfr_pkg::RAD_W'({p3_tlo_ff, 10'b0});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p4_valid_ff <= 1'b0;
      end else if (adv) begin
         p4_valid_ff <= p3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p4_bsq_ff   <= p4_bsq_in;
         p4_t_ff     <= p4_t_in;
         p4_add_ff   <= p3_add_ff;
         p4_azero_ff <= p3_azero_ff;
         p4_b_ff     <= p3_b_ff;
         p4_neg_ff   <= p3_neg_ff;
         p4_zero_ff  <= p3_zero_ff;
         p4_last_ff  <= p3_last_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 5: discriminant and the error decision. For a nonzero force, a zero
   // quadratic coefficient or a negative discriminant ends in an error with RPM 0.
   // ---------------------------------------------------------------------
   logic [tfr_pkg::RAD_W-1:0] p5_disc_in, p5_disc_ff;
   logic                      p5_err_in, p5_valid_ff;
   tfr_pkg::sq_tag_type       p5_tag_ff;

   always_comb begin
      p5_disc_in = p4_add_ff ? (p4_bsq_ff + p4_t_ff) : (p4_bsq_ff - p4_t_ff);
      p5_err_in  = !p4_zero_ff
                 && (p4_azero_ff || (!p4_add_ff && (p4_t_ff > p4_bsq_ff)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p5_valid_ff <= 1'b0;
      end else if (adv) begin
         p5_valid_ff <= p4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p5_disc_ff     <= p5_disc_in;
         p5_tag_ff.neg  <= p4_neg_ff;
         p5_tag_ff.err  <= p5_err_in;
         p5_tag_ff.zero <= p4_zero_ff;
         p5_tag_ff.last <= p4_last_ff;
         p5_tag_ff.b    <= p4_b_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Square-root row: one root bit per cell, most significant first.
   // ---------------------------------------------------------------------
   logic                          sq_valid [0:ROOT_W];
   logic [tfr_pkg::SQ_REM_W-1:0]  sq_rem   [0:ROOT_W];
   logic [ROOT_W-1:0]             sq_root  [0:ROOT_W];
   logic [tfr_pkg::RAD_W-1:0]     sq_rad   [0:ROOT_W];
   tfr_pkg::sq_tag_type           sq_tag   [0:ROOT_W];

   assign sq_valid[0] = p5_valid_ff;
   assign sq_rem[0]   = '0;
   assign sq_root[0]  = '0;
   assign sq_rad[0]   = p5_disc_ff;
   assign sq_tag[0]   = p5_tag_ff;

   for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
      tfr_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (adv),
         .in_valid  (sq_valid[i]),
         .in_rem    (sq_rem[i]),
         .in_root   (sq_root[i]),
         .in_rad    (sq_rad[i]),
         .in_tag    (sq_tag[i]),
         .out_valid (sq_valid[i+1]),
         .out_rem   (sq_rem[i+1]),
         .out_root  (sq_root[i+1]),
         .out_rad   (sq_rad[i+1]),
         .out_tag   (sq_tag[i+1])
      );
   end

   // ---------------------------------------------------------------------
   // Stage 6: numerator M*(S - b) and divisor |2a| as magnitudes.
   // ---------------------------------------------------------------------
   tfr_pkg::sq_tag_type               sq_end;
   logic signed [48:0]                diff;
   logic signed [54:0]                num;
   logic signed [tfr_pkg::COEF_W-1:0] den_a;
   logic [31:0]                       den_a_mag;
   logic [NUM_W-1:0]                  p6_num_in, p6_num_ff;
   logic [tfr_pkg::DEN_W-1:0]         p6_den_in, p6_den_ff;
   logic                              p6_valid_ff;
   tfr_pkg::dv_tag_type               p6_tag_in, p6_tag_ff;

   always_comb begin
      sq_end    = sq_tag[ROOT_W];
      diff      = $signed({2'b00, sq_root[ROOT_W]}) - 49'(sq_end.b);
      if (PHYS) begin
         // Revolutions per second to per minute: 60 = 64 - 4.
         num = (55'(diff) <<< 6) - (55'(diff) <<< 2);
      end else begin
         num = 55'(diff);
      end
      p6_num_in = num[54] ? NUM_W'(-num) : NUM_W'(num);
      den_a     = (!PHYS && sq_end.neg) ? bwd_quad_ff : fwd_quad_ff;
      den_a_mag = den_a[tfr_pkg::COEF_W-1] ? 32'(-den_a) : 32'(den_a);
      p6_den_in = {den_a_mag, 9'b0};
      p6_tag_in.neg  = sq_end.neg;
      p6_tag_in.err  = sq_end.err;
      p6_tag_in.zero = sq_end.zero;
      p6_tag_in.last = sq_end.last;
      p6_tag_in.qneg = (num[54] != den_a[tfr_pkg::COEF_W-1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p6_valid_ff <= 1'b0;
      end else if (adv) begin
         p6_valid_ff <= sq_valid[ROOT_W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p6_num_ff <= p6_num_in;
         p6_den_ff <= p6_den_in;
         p6_tag_ff <= p6_tag_in;
      end
   end

   // ---------------------------------------------------------------------
   // Divider row: one quotient bit per cell.
   // ---------------------------------------------------------------------
   logic                       dv_valid [0:NUM_W];
   logic [tfr_pkg::DEN_W-1:0]  dv_rem   [0:NUM_W];
   logic [NUM_W-1:0]           dv_nq    [0:NUM_W];
   logic [tfr_pkg::DEN_W-1:0]  dv_den   [0:NUM_W];
   tfr_pkg::dv_tag_type        dv_tag   [0:NUM_W];

   assign dv_valid[0] = p6_valid_ff;
   assign dv_rem[0]   = '0;
   assign dv_nq[0]    = p6_num_ff;
   assign dv_den[0]   = p6_den_ff;
   assign dv_tag[0]   = p6_tag_ff;

   for (genvar j = 0; j < NUM_W; j++) begin : g_div
      tfr_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (adv),
         .in_valid  (dv_valid[j]),
         .in_rem    (dv_rem[j]),
         .in_nq     (dv_nq[j]),
         .in_den    (dv_den[j]),
         .in_tag    (dv_tag[j]),
         .out_valid (dv_valid[j+1]),
         .out_rem   (dv_rem[j+1]),
         .out_nq    (dv_nq[j+1]),
         .out_den   (dv_den[j+1]),
         .out_tag   (dv_tag[j+1])
      );
   end

   // ---------------------------------------------------------------------
   // Result: sign, clamp on the side of the force, saturate to 16 bits.
   // ---------------------------------------------------------------------
   tfr_pkg::dv_tag_type            dv_end;
   logic signed [55:0]             q;
   logic signed [tfr_pkg::RPM_W-1:0] tail_rpm;
   logic                           tail_err, tail_valid;

   always_comb begin
      dv_end = dv_tag[NUM_W];
      q = dv_end.qneg ? -$signed(56'(dv_nq[NUM_W])) : $signed(56'(dv_nq[NUM_W]));
      if (PHYS && dv_end.neg) begin
         q = -q;
      end
      if (!dv_end.neg) begin
         if (q > 56'(rpm_ceil_ff)) begin
            q = 56'(rpm_ceil_ff);
         end
      end else begin
         if (q < 56'(rpm_floor_ff)) begin
            q = 56'(rpm_floor_ff);
         end
      end
      if (q > RPM_MAX) begin
         q = RPM_MAX;
      end else if (q < RPM_MIN) begin
         q = RPM_MIN;
      end
      tail_rpm   = (dv_end.err || dv_end.zero) ? '0 : tfr_pkg::RPM_W'(q);
      tail_err   = dv_end.err;
      tail_valid = dv_valid[NUM_W];
   end

   // ---------------------------------------------------------------------
   // Output register and skid register. The row keeps moving while one
   // result waits; a second waiting result parks in the skid register.
   // ---------------------------------------------------------------------
   logic                             out_valid_ff, out_err_ff, out_last_ff;
   logic signed [tfr_pkg::RPM_W-1:0] out_rpm_ff, skid_rpm_ff;
   logic                             skid_err_ff, skid_last_ff;
   logic                             take_tail, out_free;

   assign take_tail = adv && tail_valid;
   assign out_free  = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff  <= skid_valid_ff || take_tail;
         skid_valid_ff <= 1'b0;
      end else if (take_tail) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            out_rpm_ff  <= skid_rpm_ff;
            out_err_ff  <= skid_err_ff;
            out_last_ff <= skid_last_ff;
         end else begin
            out_rpm_ff  <= tail_rpm;
            out_err_ff  <= tail_err;
            out_last_ff <= dv_end.last;
         end
      end else if (take_tail) begin
         skid_rpm_ff  <= tail_rpm;
         skid_err_ff  <= tail_err;
         skid_last_ff <= dv_end.last;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_rpm_command = out_rpm_ff;
   assign rsp_math_error  = out_err_ff;
   assign rsp_last_rpm    = out_last_ff;

endmodule

// ===== design/tfr_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// tfr_sqrt_cell: one step of the digit-by-digit integer square root
// Takes two radicand bits, settles one root bit and passes the rest on.
// ----------------------------------------------------------------------------
module tfr_sqrt_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic [tfr_pkg::SQ_REM_W-1:0]      in_rem,
   input  logic [tfr_pkg::ROOT_W-1:0]        in_root,
   input  logic [tfr_pkg::RAD_W-1:0]         in_rad,
   input  tfr_pkg::sq_tag_type               in_tag,
   output logic                              out_valid,
   output logic [tfr_pkg::SQ_REM_W-1:0]      out_rem,
   output logic [tfr_pkg::ROOT_W-1:0]        out_root,
   output logic [tfr_pkg::RAD_W-1:0]         out_rad,
   output tfr_pkg::sq_tag_type               out_tag
);

   logic                           valid_ff;
   logic [tfr_pkg::SQ_REM_W-1:0]   rem_ff, rem_in, shifted, trial;
   logic [tfr_pkg::ROOT_W-1:0]     root_ff, root_in;
   logic [tfr_pkg::RAD_W-1:0]      rad_ff, rad_in;
   tfr_pkg::sq_tag_type            tag_ff;
   logic                           fits;

   always_comb begin
      shifted = {in_rem[tfr_pkg::SQ_REM_W-3:0], in_rad[tfr_pkg::RAD_W-1 -: 2]};
      trial   = {1'b0, in_root, 2'b01};
      fits    = (shifted >= trial);
      rem_in  = fits ? (shifted - trial) : shifted;
      root_in = {in_root[tfr_pkg::ROOT_W-2:0], fits};
      rad_in  = {in_rad[tfr_pkg::RAD_W-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         rad_ff  <= rad_in;
         tag_ff  <= in_tag;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_rad   = rad_ff;
   assign out_tag   = tag_ff;

endmodule

// ===== design/tfr_div_cell.sv =====
// ----------------------------------------------------------------------------
// tfr_div_cell: one step of restoring unsigned division
// Shifts one numerator bit into the remainder and settles one quotient bit.
// ----------------------------------------------------------------------------
module tfr_div_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           in_valid,
   input  logic [tfr_pkg::DEN_W-1:0]      in_rem,
   input  logic [tfr_pkg::NUM_W-1:0]      in_nq,
   input  logic [tfr_pkg::DEN_W-1:0]      in_den,
   input  tfr_pkg::dv_tag_type            in_tag,
   output logic                           out_valid,
   output logic [tfr_pkg::DEN_W-1:0]      out_rem,
   output logic [tfr_pkg::NUM_W-1:0]      out_nq,
   output logic [tfr_pkg::DEN_W-1:0]      out_den,
   output tfr_pkg::dv_tag_type            out_tag
);

   logic                          valid_ff;
   logic [tfr_pkg::DEN_W-1:0]     rem_ff, rem_in, den_ff;
   logic [tfr_pkg::NUM_W-1:0]     nq_ff, nq_in;
   logic [tfr_pkg::DEN_W:0]       shifted, diff;
   tfr_pkg::dv_tag_type           tag_ff;
   logic                          fits;

   // The numerator drains out of the top of nq while quotient bits fill it
   // from the bottom.
   always_comb begin
      shifted = {in_rem, in_nq[tfr_pkg::NUM_W-1]};
      fits    = (shifted >= {1'b0, in_den});
      diff    = shifted - {1'b0, in_den};
      rem_in  = fits ? diff[tfr_pkg::DEN_W-1:0] : shifted[tfr_pkg::DEN_W-1:0];
      nq_in   = {in_nq[tfr_pkg::NUM_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         nq_ff  <= nq_in;
         den_ff <= in_den;
         tag_ff <= in_tag;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_nq    = nq_ff;
   assign out_den   = den_ff;
   assign out_tag   = tag_ff;

endmodule

// ===== tb/thrust_force_to_rpm_checker.sv =====
// ----------------------------------------------------------------------------
// thrust_force_to_rpm_checker: result predictor and scoreboard
// Watches the force, RPM and register ports of the converter, keeps its own
// copy of the registers, works out the RPM command of every accepted force
// and compares each RPM transfer with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module thrust_force_to_rpm_checker #(
   parameter int CURVE_MODE = tfr_pkg::CURVE_MODE_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic signed [tfr_pkg::FORCE_W-1:0]  req_thrust_force,
   input  logic signed [tfr_pkg::SURGE_W-1:0]  req_surge_speed,
   input  logic                                req_last_thruster,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic signed [tfr_pkg::RPM_W-1:0]    rsp_rpm_command,
   input  logic                                rsp_math_error,
   input  logic                                rsp_last_rpm,
   input  logic                                csr_we,
   input  logic [tfr_pkg::IDX_W-1:0]           csr_index,
   input  logic [tfr_pkg::COEF_W-1:0]          csr_wdata,
   output int                                  fail_count,
   output int                                  pending
);
   import tfr_pkg::*;

   // Far more entries than the pipeline and its output registers can hold.
   localparam int EXP_DEPTH = 256;

   typedef struct {
      logic signed [RPM_W-1:0] rpm;
      logic                    err;
      logic                    last;
   } rpm_cmd_type;

   logic signed [COEF_W-1:0]  coef [6];
   logic signed [CLAMP_W-1:0] ceil_reg;
   logic signed [CLAMP_W-1:0] floor_reg;
   rpm_cmd_type               exp_mem [EXP_DEPTH];
   logic [7:0]                wr_ptr;
   logic [7:0]                rd_ptr;
   int                        exp_count;

   // Everything is carried at 128 bits so that the exact discriminant fits.
   function automatic rpm_cmd_type solve_rpm(logic signed [FORCE_W-1:0] f,
                                             logic signed [SURGE_W-1:0] s, logic l);
      rpm_cmd_type r;
      logic signed [127:0] a, b, c, d, root, cand, num, q, fmag;
      int sel;
      r.rpm  = '0;
      r.err  = 1'b0;
      r.last = l;
      if (f == 0) return r;
      if (CURVE_MODE == 0) begin
         fmag = (f < 0) ? -f : f;
         a = coef[REG_FWD_QUAD] * 256;
         b = -(coef[REG_FWD_LIN] * s);
         c = -(fmag * 16777216);
      end else begin
         sel = (f < 0) ? 3 : 0;
         a = coef[sel] * 256;
         b = coef[sel + 1] * 256;
         c = coef[sel + 2] * 256 - f * 16777216;
      end
      if (a == 0) begin
         r.err = 1'b1;
         return r;
      end
      d = b * b - 4 * a * c;
      if (d < 0) begin
         r.err = 1'b1;
         return r;
      end
      root = 0;
      for (int i = 63; i >= 0; i--) begin
         cand = root | (128'sd1 <<< i);
         if (cand * cand <= d) root = cand;
      end
      num = ((CURVE_MODE == 0) ? 60 : 1) * (root - b);
      q = num / (2 * a);
      if (CURVE_MODE == 0 && f < 0) q = -q;
      if (f > 0) begin
         if (q > ceil_reg) q = ceil_reg;
      end else begin
         if (q < floor_reg) q = floor_reg;
      end
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      r.rpm = q[RPM_W-1:0];
      return r;
   endfunction

   assign pending = exp_count;

   always @(posedge clock) begin
      rpm_cmd_type want;
      int          delta;
      delta = 0;
      if (reset) begin
         for (int i = 0; i < 6; i++) coef[i] <= '0;
         ceil_reg   <= CEIL_RST;
         floor_reg  <= FLOOR_RST;
         fail_count <= 0;
         wr_ptr     <= '0;
         rd_ptr     <= '0;
         exp_count  <= 0;
      end else begin
         if (csr_we) begin
            case (csr_idx_type'(csr_index))
               REG_RPM_CEIL:  ceil_reg  <= csr_wdata[CLAMP_W-1:0];
               REG_RPM_FLOOR: floor_reg <= csr_wdata[CLAMP_W-1:0];
               default:       coef[csr_index] <= csr_wdata;
            endcase
         end
         if (req_valid && req_ready) begin
            exp_mem[wr_ptr] <= solve_rpm(req_thrust_force, req_surge_speed,
                                         req_last_thruster);
            wr_ptr <= wr_ptr + 8'd1;
            delta  = delta + 1;
         end
         if (rsp_valid && rsp_ready) begin
            if (exp_count == 0) begin
               $display("%0t: RPM transfer with nothing outstanding: rpm %0d err %0b",
                        $time, rsp_rpm_command, rsp_math_error);
               fail_count <= fail_count + 1;
            end else begin
               want   = exp_mem[rd_ptr];
               rd_ptr <= rd_ptr + 8'd1;
               delta  = delta - 1;
               if (want.rpm !== rsp_rpm_command || want.err !== rsp_math_error ||
                   want.last !== rsp_last_rpm) begin
                  $display("%0t: mismatch: expected rpm %0d err %0b last %0b, %s %0d %0b %0b",
                           $time, want.rpm, want.err, want.last,
                           "actual rpm err last", rsp_rpm_command, rsp_math_error,
                           rsp_last_rpm);
                  fail_count <= fail_count + 1;
               end
            end
         end
         exp_count <= exp_count + delta;
      end
   end

endmodule

// ===== tb/thrust_force_to_rpm_test.sv =====
// ----------------------------------------------------------------------------
// thrust_force_to_rpm_test: top level of the converter testbench
// Drives forces and register settings into the converter, applies random
// back-pressure on the RPM side and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module thrust_force_to_rpm_test;
   import tfr_pkg::*;

   // The settle time leaves some margin beyond the depth of the pipeline.
   localparam int SETTLE     = 130;
   localparam int IDLE_LIMIT = 4000;
   localparam int RAND_PHASES = 12;
   localparam int PHASE_ITEMS = 96;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic signed [FORCE_W-1:0]  req_thrust_force = '0;
   logic signed [SURGE_W-1:0]  req_surge_speed = '0;
   logic                       req_last_thruster = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [RPM_W-1:0]    rsp_rpm_command;
   logic                       rsp_math_error;
   logic                       rsp_last_rpm;
   logic                       csr_we = 1'b0;
   logic [IDX_W-1:0]           csr_index = '0;
   logic [COEF_W-1:0]          csr_wdata = '0;
   int                         fail_count;
   int                         pending;

   // When set, neither side inserts any wait cycles.
   logic no_idle = 1'b0;
   int   rsp_stall = 0;
   int   idle_cycles = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   thrust_force_to_rpm uut (.*);

   thrust_force_to_rpm_checker u_checker (.*);

   // The receiver lowers ready for a randomly drawn stall after every RPM transfer it takes.
   always @(posedge clock) begin
      int stall;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall <= 0;
      end else begin
         stall = rsp_stall;
         if (rsp_valid && rsp_ready) stall = no_idle ? 0 : $urandom_range(0, 4);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            rsp_stall <= stall - 1;
         end else begin
            rsp_ready <= 1'b1;
            rsp_stall <= 0;
         end
      end
   end

   // The watchdog ends the run if no transfer happens on either channel for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Sends one force. A wait of zero keeps valid high straight into the next
   // transfer, so valid is never lowered and raised in the same step.
   task automatic send_force(logic signed [FORCE_W-1:0] f, logic signed [SURGE_W-1:0] s,
                             logic l);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_thrust_force  <= f;
      req_surge_speed   <= s;
      req_last_thruster <= l;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stops sending and waits until every outstanding RPM command has arrived,
   // then lets the pipeline run empty so that registers may be rewritten.
   task automatic drain;
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Writes all eight registers on consecutive edges; the enable drops afterwards.
   task automatic load_regs(logic [31:0] fa, logic [31:0] fb, logic [31:0] fc,
                            logic [31:0] ba, logic [31:0] bb, logic [31:0] bc,
                            logic [15:0] ceil_v, logic [15:0] floor_v);
      logic [31:0] vals [8];
      vals = '{fa, fb, fc, ba, bb, bc, {16'h0, ceil_v}, {16'h0, floor_v}};
      for (int i = 0; i < 8; i++) begin
         csr_we    <= 1'b1;
         csr_index <= IDX_W'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   function automatic logic [31:0] small_signed(int span);
      return 32'($signed($urandom_range(0, 2 * span)) - span);
   endfunction

   // Picks a register setting: a realistic thrust curve most of the time,
   // sometimes raw random words, sometimes the extreme codes.
   task automatic random_regs;
      int kind;
      logic [15:0] ceil_v, floor_v;
      kind = $urandom_range(0, 5);
      ceil_v  = ($urandom_range(0, 1) == 1) ? 16'h7FFF : 16'($urandom);
      floor_v = ($urandom_range(0, 1) == 1) ? 16'h8000 : 16'($urandom);
      if (kind <= 3)
         load_regs($urandom_range(1 << 6, 1 << 22), small_signed(1 << 20),
                   small_signed(1 << 22), -$urandom_range(1 << 6, 1 << 22),
                   small_signed(1 << 20), small_signed(1 << 22), ceil_v, floor_v);
      else if (kind == 4)
         load_regs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   ceil_v, floor_v);
      else
         load_regs(($urandom_range(0, 1) == 1) ? 32'h7FFF_FFFF : 32'h0000_0001,
                   ($urandom_range(0, 1) == 1) ? 32'h7FFF_FFFF : 32'h8000_0000,
                   ($urandom_range(0, 1) == 1) ? 32'h7FFF_FFFF : 32'h8000_0000,
                   ($urandom_range(0, 1) == 1) ? 32'h8000_0000 : 32'hFFFF_FFFF,
                   ($urandom_range(0, 1) == 1) ? 32'h7FFF_FFFF : 32'h8000_0000,
                   ($urandom_range(0, 1) == 1) ? 32'h7FFF_FFFF : 32'h8000_0000,
                   ceil_v, floor_v);
   endtask

   // Forces are mostly of realistic size, with full-range words and zeros mixed in.
   function automatic logic signed [FORCE_W-1:0] random_force;
      case ($urandom_range(0, 7))
         0:       return '0;
         1, 2:    return FORCE_W'($urandom);
         3:       return FORCE_W'(small_signed(256));
         default: return FORCE_W'(small_signed(1 << 16));
      endcase
   endfunction

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes with a typical forward and backward curve.
      load_regs(32'h0004_0000, 32'h0001_0000, 32'h0000_0000,
                32'hFFFC_0000, 32'hFFFF_0000, 32'h0000_0000, 16'h7FFF, 16'h8000);
      send_force(24'sd0, 16'sd0, 1'b0);
      send_force(24'sh7FFFFF, 16'sh7FFF, 1'b1);
      send_force(-24'sh800000, -16'sh8000, 1'b0);
      send_force(24'sd1, 16'sd1, 1'b1);
      send_force(-24'sd1, -16'sd1, 1'b0);
      send_force(24'sd25600, 16'sd256, 1'b1);
      send_force(-24'sd25600, -16'sd256, 1'b0);
      drain();

      // Zero quadratic coefficient in both sets, then a negative discriminant.
      load_regs(32'h0, 32'h0100_0000, 32'h0, 32'h0, 32'h0100_0000, 32'h0,
                16'h7FFF, 16'h8000);
      send_force(24'sd512, 16'sd0, 1'b0);
      send_force(-24'sd512, 16'sd0, 1'b1);
      drain();
      load_regs(32'h0100_0000, 32'h0, 32'h7FFF_FFFF, 32'hFF00_0000, 32'h0, 32'h8000_0000,
                16'h7FFF, 16'h8000);
      send_force(24'sd256, 16'sd0, 1'b0);
      send_force(-24'sd256, 16'sd0, 1'b1);
      drain();

      // Clamp registers crossed over, and a tiny coefficient that overflows 16 bits.
      load_regs(32'h0000_0001, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0,
                16'hFF9C, 16'h0064);
      send_force(24'sh7FFFFF, 16'sd0, 1'b0);
      send_force(-24'sh800000, 16'sd0, 1'b1);
      send_force(24'sd1, 16'sd0, 1'b0);
      drain();
      load_regs(32'h0000_0001, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h8000, 16'h7FFF);
      send_force(24'sh7FFFFF, 16'sh7FFF, 1'b1);
      send_force(-24'sh800000, -16'sh8000, 1'b0);
      send_force(24'sd100, 16'sd0, 1'b1);
      drain();

      // Random phases; every fourth one runs without any wait cycles.
      for (int p = 0; p < RAND_PHASES; p++) begin
         no_idle <= (p % 4 == 3);
         random_regs();
         for (int n = 0; n < PHASE_ITEMS; n++)
            send_force(random_force(), SURGE_W'($urandom), 1'($urandom));
         drain();
      end

      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
